// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define LSDRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define LSDRS_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/lsdrs_pkg.sv
package lsdrs_pkg;

	localparam int KEY_W     = 24;
	localparam int MAX_ITEMS = 64;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int RADIX     = 10;
	localparam int DIG_W     = 4;
	localparam int PLACE_W   = 3;
	localparam int PROD_W    = 2 * KEY_W;

	// floor(x / 10) == (x * RECIP10) >> RECIP_SH, exact for any 24-bit x
	localparam logic [KEY_W-1:0] RECIP10  = 24'hCCCCCD;
	localparam int               RECIP_SH = 27;

	// One stored element: the key and the key divided by 10^pass.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] res;
	} entry_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] quot;
		logic [DIG_W-1:0] digit;
	} digit_res_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PASS_CHK,
		ST_CNT_RD,
		ST_CNT_DRAIN,
		ST_PREFIX,
		ST_SCAT_RD,
		ST_SCAT_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_HOLD
	} state_t;

endpackage

// File: rtl/core/lsdrs_digit.sv
module lsdrs_digit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  lsdrs_pkg::entry_t   in_entry,
	output lsdrs_pkg::digit_res_t dres
);
	import lsdrs_pkg::*;

	logic              valid_s1;
	entry_t            ent_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [KEY_W-1:0]  quot;
	logic [KEY_W-1:0]  tenq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ent_s1  <= in_entry;
		prod_s1 <= in_entry.res * RECIP10;
	end

	always_comb begin
		quot       = KEY_W'(prod_s1[PROD_W-1:RECIP_SH]);
		tenq       = KEY_W'({quot, 3'b000}) + KEY_W'({quot, 1'b0});
		dres.valid = valid_s1;
		dres.key   = ent_s1.key;
		dres.quot  = quot;
		dres.digit = DIG_W'(ent_s1.res - tenq);
	end

endmodule

// File: rtl/core/lsd_decimal_radix_sort.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------
// in       | in_valid / in_ready   | key_value[23:0], is_last
// out      | out_valid / out_ready | sorted_value[23:0], is_final, items_dropped
// cfg      | cfg_we                | cfg_wdata[2:0] (digit places)
//
// Loading accepts one request per cycle; in_ready is high only while loading.
// Each digit pass over the keys is a count sweep and a scatter sweep through the
// key memory (one read a cycle), plus a bucket offset scan over the ten digits.
// Emitting reads each key, registers it and holds it until out_ready.
// Reset clears control state only; the key memories need no clearing.
module lsd_decimal_radix_sort (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lsdrs_pkg::KEY_W-1:0]   key_value,
	input  logic                          is_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lsdrs_pkg::KEY_W-1:0]   sorted_value,
	output logic                          is_final,
	output logic                          items_dropped,
	input  logic                          cfg_we,
	input  logic [lsdrs_pkg::PLACE_W-1:0] cfg_wdata
);
	import lsdrs_pkg::*;

	state_t state_q, state_d;

	logic [PLACE_W-1:0] places_q;
	logic [PLACE_W-1:0] pass_q;
	logic [CNT_W-1:0]   item_cnt_q;
	logic               ovf_q;
	logic               cur_q;       // memory holding the current order
	logic [CNT_W-1:0]   idx_q;
	logic [DIG_W-1:0]   pfx_q;
	logic [CNT_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_q   [RADIX];
	logic [CNT_W-1:0]   start_q [RADIX];
	logic               rd_vld_q;

	entry_t mem0_q [MAX_ITEMS];
	entry_t mem1_q [MAX_ITEMS];
	entry_t rd0_q, rd1_q, rdata;

	logic               out_valid_q, is_final_q;
	logic [KEY_W-1:0]   sorted_q;

	logic               rd_en, last_idx, in_acc, out_acc, drained;
	logic               scat_wr, load_wr;
	logic               we0, we1;
	logic [ADDR_W-1:0]  waddr;
	entry_t             wdata;
	digit_res_t         dres;

	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid_q && out_ready;
	assign last_idx = (idx_q + CNT_W'(1)) == item_cnt_q;
	assign drained  = !rd_vld_q && !dres.valid;
	assign rdata    = cur_q ? rd1_q : rd0_q;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid && is_last) state_d = ST_PASS_CHK;
			end
			ST_PASS_CHK: begin
				state_d = (pass_q >= places_q) ? ST_EMIT_RD : ST_CNT_RD;
			end
			ST_CNT_RD: begin
				rd_en = 1'b1;
				if (last_idx) state_d = ST_CNT_DRAIN;
			end
			ST_CNT_DRAIN: begin
				if (drained) state_d = ST_PREFIX;
			end
			ST_PREFIX: begin
				if (pfx_q == DIG_W'(RADIX - 1)) state_d = ST_SCAT_RD;
			end
			ST_SCAT_RD: begin
				rd_en = 1'b1;
				if (last_idx) state_d = ST_SCAT_DRAIN;
			end
			ST_SCAT_DRAIN: begin
				if (drained) state_d = ST_PASS_CHK;
			end
			ST_EMIT_RD: begin
				rd_en   = 1'b1;
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				state_d = ST_EMIT_HOLD;
			end
			ST_EMIT_HOLD: begin
				if (out_ready) state_d = is_final_q ? ST_LOAD : ST_EMIT_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// scatter results land in the memory not holding the current order
	always_comb begin
		scat_wr = dres.valid && (state_q == ST_SCAT_RD || state_q == ST_SCAT_DRAIN);
		load_wr = in_acc && (item_cnt_q != CNT_W'(MAX_ITEMS));
		we0     = load_wr || (scat_wr && cur_q);
		we1     = scat_wr && !cur_q;
		if (load_wr) begin
			waddr     = item_cnt_q[ADDR_W-1:0];
			wdata.key = key_value;
			wdata.res = key_value;
		end else begin
			waddr     = start_q[dres.digit][ADDR_W-1:0];
			wdata.key = dres.key;
			wdata.res = dres.quot;
		end
	end

	always_ff @(posedge clk) begin
		if (we0) mem0_q[waddr] <= wdata;
		if (we1) mem1_q[waddr] <= wdata;
		rd0_q <= mem0_q[idx_q[ADDR_W-1:0]];
		rd1_q <= mem1_q[idx_q[ADDR_W-1:0]];
	end

	lsdrs_digit u_digit (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(rd_vld_q && state_q != ST_EMIT_LD),
		.in_entry(rdata),
		.dres    (dres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			places_q    <= PLACE_W'(7);
			pass_q      <= '0;
			item_cnt_q  <= '0;
			ovf_q       <= 1'b0;
			cur_q       <= 1'b0;
			idx_q       <= '0;
			pfx_q       <= '0;
			sum_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < RADIX; i++) begin
				cnt_q[i]   <= '0;
				start_q[i] <= '0;
			end
		end else begin
			state_q  <= state_d;
			rd_vld_q <= rd_en;
			if (cfg_we) places_q <= cfg_wdata;

			if (in_acc) begin
				if (load_wr) item_cnt_q <= item_cnt_q + CNT_W'(1);
				else         ovf_q      <= 1'b1;
				if (is_last) begin
					cur_q  <= 1'b0;
					pass_q <= '0;
				end
			end

			if (state_q == ST_PASS_CHK) begin
				idx_q <= '0;
				pfx_q <= '0;
				sum_q <= '0;
				for (int i = 0; i < RADIX; i++) cnt_q[i] <= '0;
			end

			if ((state_q == ST_CNT_RD || state_q == ST_SCAT_RD) && rd_en) begin
				idx_q <= last_idx ? '0 : idx_q + CNT_W'(1);
			end

			if (state_q == ST_CNT_RD || state_q == ST_CNT_DRAIN) begin
				if (dres.valid) cnt_q[dres.digit] <= cnt_q[dres.digit] + CNT_W'(1);
			end

			if (state_q == ST_PREFIX) begin
				start_q[pfx_q] <= sum_q;
				sum_q          <= sum_q + cnt_q[pfx_q];
				pfx_q          <= pfx_q + DIG_W'(1);
			end

			if (scat_wr) start_q[dres.digit] <= start_q[dres.digit] + CNT_W'(1);

			if (state_q == ST_SCAT_DRAIN && drained) begin
				cur_q  <= !cur_q;
				pass_q <= pass_q + PLACE_W'(1);
			end

			if (state_q == ST_EMIT_LD) out_valid_q <= 1'b1;

			if (state_q == ST_EMIT_HOLD && out_acc) begin
				out_valid_q <= 1'b0;
				if (is_final_q) begin
					item_cnt_q <= '0;
					ovf_q      <= 1'b0;
					idx_q      <= '0;
				end else begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD) begin
			sorted_q   <= rdata.key;
			is_final_q <= last_idx;
		end
	end

	assign out_valid     = out_valid_q;
	assign sorted_value  = sorted_q;
	assign is_final      = is_final_q;
	assign items_dropped = ovf_q;

endmodule

// File: rtl/core/lsdrs_checker.sv
`include "assert_macros.svh"

module lsdrs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [lsdrs_pkg::KEY_W-1:0]   key_value,
	input logic                          is_last,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [lsdrs_pkg::KEY_W-1:0]   sorted_value,
	input logic                          is_final,
	input logic                          items_dropped,
	input logic                          cfg_we,
	input logic [lsdrs_pkg::PLACE_W-1:0] cfg_wdata
);

	// loading and emitting never overlap
	`LSDRS_ASSERT(a_no_load_while_emit, !(in_ready && out_valid), "load during emit")

	`LSDRS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(sorted_value) && $stable(is_final) && $stable(items_dropped), "stalled result changed")

	// a closing request starts the sort, so loading stops
	`LSDRS_ASSERT(a_last_stops_load, in_valid && in_ready && is_last |=> !in_ready, "load after last")

	`LSDRS_ASSERT(a_final_ends_run, out_valid && out_ready && is_final |=> !out_valid, "result after final")

	`LSDRS_ASSERT_RST(a_reset_quiet, !arst_n |-> !out_valid, "result during reset")

endmodule

bind lsd_decimal_radix_sort lsdrs_checker u_lsdrs_checker (.*);
